### hw/rtl/lzx_pkg.sv
// Package for the LZ77 token expander: payload structs, token and queue types,
// state enums and fixed widths. It depends on nothing else.
package lzx_pkg;

    // Fixed field widths of the two channels.
    localparam int LIT_W       = 8;
    localparam int LEN_W       = 9;
    localparam int OFF_W       = 16;
    localparam int GROUP_BYTES = 8;
    localparam int LANE_W      = $clog2(GROUP_BYTES);
    localparam int OUT_W       = 8 * GROUP_BYTES;
    localparam int CNT_W       = 4;

    // Token queue between the front and back parts.
    localparam int Q_DEPTH = 2;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One input item.
    typedef struct packed {
        logic [LIT_W-1:0] literal_byte;
        logic [LEN_W-1:0] match_length;
        logic [OFF_W-1:0] match_offset;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [OUT_W-1:0] out_bytes;
        logic [CNT_W-1:0] byte_count;
        logic             last_of_token;
    } t_out_item;

    typedef enum logic {
        TK_LITERAL = 1'b0,
        TK_COPY    = 1'b1
    } t_tok_kind;

    // A classified token with its distance already reduced into the history.
    typedef struct packed {
        t_tok_kind        kind;
        logic [LIT_W-1:0] literal_byte;
        logic [LEN_W-1:0] length;
        logic [OFF_W-1:0] distance;
    } t_token;

    // Queue status seen by both neighbors.
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_flags;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_REDUCE,
        FR_PUSH
    } t_fr_state;

    typedef enum logic {
        BK_IDLE,
        BK_ISSUE
    } t_bk_state;

endpackage

### hw/rtl/lz77_token_expander.sv
// Top level of the LZ77 token expander: front classifier, token queue and
// back copy engine. Depends on lzx_pkg, lzx_front, lzx_queue and lzx_back.
//
//   Channel | Direction | Handshake                | Payload
//   input   | in        | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//   output  | out       | o_out_valid / i_out_ready| o_out_data (t_out_item)
//
// A literal goes from idle straight to the push state in the front; a copy first
// passes through the one-subtract-per-cycle offset reduction.
// The back loads a token while idle and then reads one byte per cycle from the
// history memory, as long as the output is not stalled.
// Front and back work on different tokens at once through a two-entry queue.
// Reset is synchronous and needs no clearing pass: unwritten history reads as zero.
// A stalled output holds the byte pipeline, and a full queue holds the front.
module lz77_token_expander import lzx_pkg::*; #(
    parameter int WIN_BYTES = 32768
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int HIST_SIZE = 2 * WIN_BYTES;

    logic     push, pop;
    t_token   push_tok, head_tok;
    t_q_flags q_flags;

    lzx_front #(
        .HIST_SIZE (HIST_SIZE)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_ready (o_in_ready),
        .i_q        (q_flags),
        .o_push     (push),
        .o_tok      (push_tok)
    );

    lzx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok   (push_tok),
        .i_pop   (pop),
        .o_head  (head_tok),
        .o_flags (q_flags)
    );

    lzx_back #(
        .HIST_SIZE (HIST_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_tok),
        .i_q         (q_flags),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### hw/rtl/lzx_front.sv
// Front part of the LZ77 token expander: accepts tokens, classifies them and
// reduces the offset modulo the history size. Depends on lzx_pkg.
module lzx_front import lzx_pkg::*; #(
    parameter int HIST_SIZE = 65536
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_ready,
    input  t_q_flags i_q,
    output logic     o_push,
    output t_token   o_tok
);

    // Restoring reduction: one conditional subtract of a shifted history size per cycle.
    localparam int HA         = $clog2(HIST_SIZE);
    localparam int NSTEP      = 17 - HA;
    localparam int SW         = $clog2(NSTEP + 1);
    localparam int DW         = OFF_W + 1;
    localparam logic [DW-1:0] DIV_START = DW'(HIST_SIZE * (2 ** (NSTEP - 1)));

    t_fr_state         r_state, n_state;
    logic [OFF_W-1:0]  r_off, n_off;
    logic [DW-1:0]     r_div, n_div;
    logic [SW-1:0]     r_step, n_step;
    t_token            r_tok, n_tok;

    logic in_take;
    logic in_copy;
    logic in_literal;

    assign in_take    = i_in_valid && o_in_ready;
    assign in_literal = (i_in_data.match_length == '0) && (i_in_data.match_offset == '0);
    assign in_copy    = (i_in_data.match_length != '0);

    // State register and token registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_off  <= n_off;
        r_div  <= n_div;
        r_step <= n_step;
        r_tok  <= n_tok;
    end

    // Next state, reduction step and queue push.
    always_comb begin
        n_state        = r_state;
        n_off          = r_off;
        n_div          = r_div;
        n_step         = r_step;
        n_tok          = r_tok;
        o_in_ready     = 1'b0;
        o_push         = 1'b0;
        o_tok          = r_tok;
        o_tok.distance = r_off;
        unique case (r_state)
            FR_IDLE: begin
                o_in_ready = 1'b1;
                if (in_take) begin
                    n_tok.literal_byte = i_in_data.literal_byte;
                    n_tok.length       = i_in_data.match_length;
                    priority if (in_literal) begin
                        n_tok.kind = TK_LITERAL;
                        n_off      = '0;
                        n_state    = FR_PUSH;
                    end else if (in_copy) begin
                        n_tok.kind = TK_COPY;
                        n_off      = i_in_data.match_offset;
                        n_div      = DIV_START;
                        n_step     = SW'(NSTEP);
                        n_state    = FR_REDUCE;
                    end else begin
                        // An empty match produces nothing and is dropped here.
                        n_state = FR_IDLE;
                    end
                end
            end
            FR_REDUCE: begin
                if ({1'b0, r_off} >= r_div) begin
                    n_off = OFF_W'({1'b0, r_off} - r_div);
                end
                n_div  = r_div >> 1;
                n_step = r_step - SW'(1);
                if (r_step == SW'(1)) begin
                    n_state = FR_PUSH;
                end
            end
            FR_PUSH: begin
                o_push = !i_q.full;
                if (!i_q.full) begin
                    n_state = FR_IDLE;
                end
            end
            default: begin
                n_state = FR_IDLE;
            end
        endcase
    end

    // A pushed copy always carries a distance inside the history.
    a_dist_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && (r_tok.kind == TK_COPY)) |-> ({1'b0, r_off} < DW'(HIST_SIZE)))
        else $error("front pushed an unreduced distance");

    // The queue is never written while full.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q.full)
        else $error("front pushed into a full queue");

    // An accepted empty match leaves the front idle.
    a_empty_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !in_literal && !in_copy) |=> (r_state == FR_IDLE))
        else $error("empty match was not dropped");

endmodule

### hw/rtl/lzx_queue.sv
// Two-entry token queue between the front and back parts of the expander.
// Depends on lzx_pkg for the token and status types.
module lzx_queue import lzx_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_token   i_tok,
    input  logic     i_pop,
    output t_token   o_head,
    output t_q_flags o_flags
);

    t_token              r_mem [Q_DEPTH];
    logic [Q_IDX_W-1:0]  r_wr, r_rd;
    logic [Q_CNT_W-1:0]  r_cnt;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_IDX_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_IDX_W'(1);
            end
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_tok;
        end
    end

    assign o_head        = r_mem[r_rd];
    assign o_flags.empty = (r_cnt == '0);
    assign o_flags.full  = (r_cnt == Q_CNT_W'(Q_DEPTH));

endmodule

### hw/rtl/lzx_back.sv
// Back part of the LZ77 token expander: history memory, byte copy pipeline
// and output group packer with its output register. Depends on lzx_pkg.
module lzx_back import lzx_pkg::*; #(
    parameter int HIST_SIZE = 65536
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_token    i_head,
    input  t_q_flags  i_q,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int             AW       = $clog2(HIST_SIZE);
    localparam logic [AW-1:0]  LAST_IDX = AW'(HIST_SIZE - 1);
    localparam logic [AW:0]    HIST_EXT = (AW + 1)'(HIST_SIZE);

    // History memory; an entry never written reads as zero through the fill tracking.
    logic [7:0]        r_hist [HIST_SIZE];
    logic [7:0]        r_q;

    // Issue stage.
    t_bk_state         r_state, n_state;
    logic [AW-1:0]     r_rp, n_rp;
    logic [AW-1:0]     r_iwp, n_iwp;
    logic [LEN_W-1:0]  r_remain, n_remain;
    logic              r_lit, n_lit;
    logic [7:0]        r_litbyte, n_litbyte;

    // Data stage.
    logic              r_d_valid, r_d_last, r_d_lit, r_d_hit, r_d_fwd;
    logic [7:0]        r_d_litbyte, r_fwd_byte;

    // Write side and packer.
    logic [AW-1:0]     r_wp;
    logic              r_full;
    logic [OUT_W-1:0]  r_acc, acc_new;
    logic [LANE_W-1:0] r_fill;
    logic              r_o_valid;
    t_out_item         r_o_data;

    logic [7:0]        d_byte;
    logic              group_done, out_free, d_go, issue;
    logic [AW:0]       rp_sum;
    logic [AW-1:0]     rp_start, wp_next, iwp_after;

    // Byte of the data stage: literal, forwarded write, stored entry or unwritten zero.
    always_comb begin
        priority if (r_d_lit) begin
            d_byte = r_d_litbyte;
        end else if (r_d_fwd) begin
            d_byte = r_fwd_byte;
        end else if (r_d_hit) begin
            d_byte = r_q;
        end else begin
            d_byte = '0;
        end
    end

    assign group_done = r_d_last || (r_fill == LANE_W'(GROUP_BYTES - 1));
    assign out_free   = !r_o_valid || i_out_ready;
    assign d_go       = r_d_valid && (!group_done || out_free);
    assign issue      = (r_state == BK_ISSUE) && (!r_d_valid || d_go);
    assign o_pop      = (r_state == BK_IDLE) && !i_q.empty;

    assign wp_next   = (r_wp == LAST_IDX) ? '0 : r_wp + AW'(1);
    assign iwp_after = r_d_valid ? wp_next : r_wp;

    // Start of the copy: write position minus distance, wrapped into the history.
    assign rp_sum   = {1'b0, r_iwp} + HIST_EXT - {1'b0, i_head.distance[AW-1:0]};
    assign rp_start = (rp_sum >= HIST_EXT) ? AW'(rp_sum - HIST_EXT) : rp_sum[AW-1:0];

    // Issue-side next state: pop a token, then issue one byte per free cycle.
    always_comb begin
        n_state   = r_state;
        n_rp      = r_rp;
        n_iwp     = r_iwp;
        n_remain  = r_remain;
        n_lit     = r_lit;
        n_litbyte = r_litbyte;
        unique case (r_state)
            BK_IDLE: begin
                if (o_pop) begin
                    n_lit     = (i_head.kind == TK_LITERAL);
                    n_litbyte = i_head.literal_byte;
                    n_remain  = (i_head.kind == TK_LITERAL) ? LEN_W'(1) : i_head.length;
                    n_rp      = rp_start;
                    n_state   = BK_ISSUE;
                end
            end
            BK_ISSUE: begin
                if (issue) begin
                    n_rp     = (r_rp == LAST_IDX) ? '0 : r_rp + AW'(1);
                    n_iwp    = (r_iwp == LAST_IDX) ? '0 : r_iwp + AW'(1);
                    n_remain = r_remain - LEN_W'(1);
                    if (r_remain == LEN_W'(1)) begin
                        n_state = BK_IDLE;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Place the data-stage byte in its lane.
    always_comb begin
        acc_new = r_acc;
        acc_new[{r_fill, 3'b000} +: 8] = d_byte;
    end

    // Control registers of both stages, packer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_IDLE;
            r_iwp     <= '0;
            r_wp      <= '0;
            r_full    <= 1'b0;
            r_d_valid <= 1'b0;
            r_acc     <= '0;
            r_fill    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_iwp   <= n_iwp;
            if (issue) begin
                r_d_valid <= 1'b1;
            end else if (d_go) begin
                r_d_valid <= 1'b0;
            end
            if (d_go) begin
                r_wp <= wp_next;
                if (r_wp == LAST_IDX) begin
                    r_full <= 1'b1;
                end
                if (group_done) begin
                    r_acc  <= '0;
                    r_fill <= '0;
                end else begin
                    r_acc  <= acc_new;
                    r_fill <= r_fill + LANE_W'(1);
                end
            end
            if (d_go && group_done) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers of the issue and data stages.
    always_ff @(posedge i_clk) begin
        r_rp      <= n_rp;
        r_remain  <= n_remain;
        r_lit     <= n_lit;
        r_litbyte <= n_litbyte;
        if (issue) begin
            r_d_last    <= (r_remain == LEN_W'(1));
            r_d_lit     <= r_lit;
            r_d_litbyte <= r_litbyte;
            r_d_hit     <= r_full || (r_rp < r_wp);
            r_d_fwd     <= d_go && (r_rp == r_wp);
            r_fwd_byte  <= d_byte;
        end
        if (d_go && group_done) begin
            r_o_data.out_bytes     <= acc_new;
            r_o_data.byte_count    <= CNT_W'({1'b0, r_fill}) + CNT_W'(1);
            r_o_data.last_of_token <= r_d_last;
        end
    end

    // History memory: write on data-stage advance, registered read on issue.
    always_ff @(posedge i_clk) begin
        if (d_go) begin
            r_hist[r_wp] <= d_byte;
        end
        if (issue) begin
            r_q <= r_hist[r_rp];
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    // The issue pointer runs exactly one position ahead when the data stage is busy.
    a_ptr_tie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iwp == iwp_after)
        else $error("issue and write positions out of step");

    // A stalled data stage blocks the next read.
    a_stall_blocks_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && !d_go) |-> !issue)
        else $error("read issued while the data stage was stalled");

    // Every emitted group carries one to eight bytes.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> ((r_o_data.byte_count != '0)
                       && (r_o_data.byte_count <= CNT_W'(GROUP_BYTES))))
        else $error("group byte count out of range");

endmodule
